[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Assertion on the default clk_i and rst_ni of the module.
`define ASSERT_DFLT(lbl, prop, msg) \
  `ASSERT_CLKD(lbl, clk_i, rst_ni, prop, msg)
`else
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg)
`define ASSERT_DFLT(lbl, prop, msg)
`endif
`endif

[sv/segi_pkg.sv]
// ---------------------------------------------------------------------------
// Segment intersection package
// Default widths and a shared helper for the segment intersection core.
// ---------------------------------------------------------------------------
package segi_pkg;

  // Default coordinate width and fraction width of the crossing point.
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  // A straddle holds when exactly one of the two cross products is positive.
  function automatic logic straddle(logic pos_s, logic pos_e);
    return pos_s ^ pos_e;
  endfunction

endpackage

[sv/segment_intersection_core.sv]
// Throughput: one segment pair per cycle while the output is not held; the division
// runs as one quotient bit per pipeline stage, so a new pair can enter every cycle.
// The whole pipeline halts together while a finished result waits downstream.
// Reset (rst_ni low, asynchronous) clears all valid bits; the data path is not reset.
// ---------------------------------------------------------------------------
// Segment intersection core
// Cross-product straddle test of two segments with a fixed-point crossing point.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module segment_intersection_core import segi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int IN_W      = ((8 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_RAW   = 1 + 2 * (COORD_BITS + FRAC_BITS) + 4 * (2 * COORD_BITS + 2),
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // hit, cross_x, cross_y, side_b_end_on_a, side_b_start_on_a,
  // side_a_end_on_b, side_a_start_on_b
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int CB = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int DW = CB + 1;
  localparam int SW = 2 * CB + 2;
  localparam int PW = CB + FB;
  localparam int QB = CB + FB + 1;
  localparam int NW = DW + SW + FB;

  // Pipeline advance: everything moves unless the output holds an untaken result.
  logic adv;
  logic s_fire;
  logic out_vld_q;

  assign adv           = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = adv;
  assign s_fire        = s_axis_tvalid & adv;

  // Valid bits of stages 1 to 4 and of the division stages 0 to QB.
  logic [3:0]  vld_q;
  logic [QB:0] dvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      dvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[2:0], s_axis_tvalid};
      dvld_q    <= {dvld_q[QB-1:0], vld_q[3]};
      out_vld_q <= dvld_q[QB];
    end
  end

  // Stage 1: coordinate differences.
  logic signed [DW-1:0] e [8];
  logic signed [DW-1:0] mx_d, my_d, qx_d, qy_d, pex_d, pey_d, psx_d, psy_d;
  logic signed [DW-1:0] aebx_d, aeby_d, asbx_d, asby_d;
  logic signed [DW-1:0] mx1_q, my1_q, qx_q, qy_q, pex_q, pey_q, psx_q, psy_q;
  logic signed [DW-1:0] aebx_q, aeby_q, asbx_q, asby_q;
  logic signed [CB-1:0] asx1_q, asy1_q;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      e[k] = DW'($signed(s_axis_tdata[k*CB +: CB]));
    end
    mx_d   = e[2] - e[0];
    my_d   = e[3] - e[1];
    qx_d   = e[6] - e[4];
    qy_d   = e[7] - e[5];
    pex_d  = e[6] - e[0];
    pey_d  = e[7] - e[1];
    psx_d  = e[4] - e[0];
    psy_d  = e[5] - e[1];
    aebx_d = e[2] - e[4];
    aeby_d = e[3] - e[5];
    asbx_d = e[0] - e[4];
    asby_d = e[1] - e[5];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mx1_q  <= mx_d;
      my1_q  <= my_d;
      qx_q   <= qx_d;
      qy_q   <= qy_d;
      pex_q  <= pex_d;
      pey_q  <= pey_d;
      psx_q  <= psx_d;
      psy_q  <= psy_d;
      aebx_q <= aebx_d;
      aeby_q <= aeby_d;
      asbx_q <= asbx_d;
      asby_q <= asby_d;
      asx1_q <= $signed(s_axis_tdata[0 +: CB]);
      asy1_q <= $signed(s_axis_tdata[CB +: CB]);
    end
  end

  // Stage 2: the twelve partial products of the cross products.
  logic signed [SW-1:0] pr_q [12];
  logic signed [DW-1:0] mx2_q, my2_q;
  logic signed [CB-1:0] asx2_q, asy2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pr_q[0]  <= mx1_q * pey_q;
      pr_q[1]  <= my1_q * pex_q;
      pr_q[2]  <= mx1_q * psy_q;
      pr_q[3]  <= my1_q * psx_q;
      pr_q[4]  <= qx_q * aeby_q;
      pr_q[5]  <= qy_q * aebx_q;
      pr_q[6]  <= qx_q * asby_q;
      pr_q[7]  <= qy_q * asbx_q;
      pr_q[8]  <= qx_q * pey_q;
      pr_q[9]  <= qy_q * pex_q;
      pr_q[10] <= qx_q * my1_q;
      pr_q[11] <= qy_q * mx1_q;
      mx2_q    <= mx1_q;
      my2_q    <= my1_q;
      asx2_q   <= asx1_q;
      asy2_q   <= asy1_q;
    end
  end

  // Stage 3: cross products, numerator and denominator.
  logic signed [SW-1:0] rba3_q, rbs3_q, rae3_q, ras3_q, pn_q, mn_q;
  logic signed [DW-1:0] mx3_q, my3_q;
  logic signed [CB-1:0] asx3_q, asy3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rba3_q <= pr_q[0] - pr_q[1];
      rbs3_q <= pr_q[2] - pr_q[3];
      rae3_q <= pr_q[4] - pr_q[5];
      ras3_q <= pr_q[6] - pr_q[7];
      pn_q   <= pr_q[8] - pr_q[9];
      mn_q   <= pr_q[10] - pr_q[11];
      mx3_q  <= mx2_q;
      my3_q  <= my2_q;
      asx3_q <= asx2_q;
      asy3_q <= asy2_q;
    end
  end

  // Stage 4: straddle test, signs and magnitudes for the division.
  logic pos_ba, pos_bs, pos_ae, pos_as;
  logic hit4_q, mnz4_q, negx4_q, negy4_q;
  logic [DW-1:0] amx_q, amy_q;
  logic [SW-1:0] bpn_q, dmn4_q;
  logic signed [SW-1:0] rba4_q, rbs4_q, rae4_q, ras4_q;
  logic signed [CB-1:0] asx4_q, asy4_q;

  assign pos_ba = ~rba3_q[SW-1] & (rba3_q != '0);
  assign pos_bs = ~rbs3_q[SW-1] & (rbs3_q != '0);
  assign pos_ae = ~rae3_q[SW-1] & (rae3_q != '0);
  assign pos_as = ~ras3_q[SW-1] & (ras3_q != '0);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit4_q  <= straddle(pos_ba, pos_bs) & straddle(pos_ae, pos_as);
      mnz4_q  <= (mn_q == '0);
      negx4_q <= mx3_q[DW-1] ^ pn_q[SW-1] ^ mn_q[SW-1];
      negy4_q <= my3_q[DW-1] ^ pn_q[SW-1] ^ mn_q[SW-1];
      amx_q   <= mx3_q[DW-1] ? DW'(-mx3_q) : DW'(mx3_q);
      amy_q   <= my3_q[DW-1] ? DW'(-my3_q) : DW'(my3_q);
      bpn_q   <= pn_q[SW-1] ? SW'(-pn_q) : SW'(pn_q);
      dmn4_q  <= mn_q[SW-1] ? SW'(-mn_q) : SW'(mn_q);
      rba4_q  <= rba3_q;
      rbs4_q  <= rbs3_q;
      rae4_q  <= rae3_q;
      ras4_q  <= ras3_q;
      asx4_q  <= asx3_q;
      asy4_q  <= asy3_q;
    end
  end

  // Division pipeline: index 0 holds the scaled dividends, index k the state
  // after k quotient bits. The sideband travels beside it.
  logic [NW-1:0]        nx_d, ny_d;
  logic [SW-1:0]        remx [QB+1];
  logic [SW-1:0]        remy [QB+1];
  logic [QB-1:0]        qlx  [QB+1];
  logic [QB-1:0]        qly  [QB+1];
  logic [SW-1:0]        dmn_q [QB+1];
  logic                 hit_p [QB+1];
  logic                 mnz_p [QB+1];
  logic                 negx_p [QB+1];
  logic                 negy_p [QB+1];
  logic signed [CB-1:0] asx_p [QB+1];
  logic signed [CB-1:0] asy_p [QB+1];
  logic signed [SW-1:0] rba_p [QB+1];
  logic signed [SW-1:0] rbs_p [QB+1];
  logic signed [SW-1:0] rae_p [QB+1];
  logic signed [SW-1:0] ras_p [QB+1];

  // Full-width magnitude products, scaled by the fraction bits.
  assign nx_d = ({{(NW-DW){1'b0}}, amx_q} * {{(NW-SW){1'b0}}, bpn_q}) << FB;
  assign ny_d = ({{(NW-DW){1'b0}}, amy_q} * {{(NW-SW){1'b0}}, bpn_q}) << FB;

  // Stage 5: magnitude products, split into first remainder and low dividend bits.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      remx[0] <= nx_d[NW-1:QB];
      qlx[0]  <= nx_d[QB-1:0];
      remy[0] <= ny_d[NW-1:QB];
      qly[0]  <= ny_d[QB-1:0];
    end
  end

  // Sideband registers along the division stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmn_q[0]  <= dmn4_q;
      hit_p[0]  <= hit4_q;
      mnz_p[0]  <= mnz4_q;
      negx_p[0] <= negx4_q;
      negy_p[0] <= negy4_q;
      asx_p[0]  <= asx4_q;
      asy_p[0]  <= asy4_q;
      rba_p[0]  <= rba4_q;
      rbs_p[0]  <= rbs4_q;
      rae_p[0]  <= rae4_q;
      ras_p[0]  <= ras4_q;
      for (int k = 1; k <= QB; k++) begin
        dmn_q[k]  <= dmn_q[k-1];
        hit_p[k]  <= hit_p[k-1];
        mnz_p[k]  <= mnz_p[k-1];
        negx_p[k] <= negx_p[k-1];
        negy_p[k] <= negy_p[k-1];
        asx_p[k]  <= asx_p[k-1];
        asy_p[k]  <= asy_p[k-1];
        rba_p[k]  <= rba_p[k-1];
        rbs_p[k]  <= rbs_p[k-1];
        rae_p[k]  <= rae_p[k-1];
        ras_p[k]  <= ras_p[k-1];
      end
    end
  end

  // One quotient bit per stage for each coordinate lane.
  for (genvar g = 0; g < QB; g++) begin : g_div
    segi_div_step #(.SW(SW), .QB(QB)) u_step_x (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (remx[g]),
      .ql_i  (qlx[g]),
      .d_i   (dmn_q[g]),
      .rem_o (remx[g+1]),
      .ql_o  (qlx[g+1])
    );
    segi_div_step #(.SW(SW), .QB(QB)) u_step_y (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (remy[g]),
      .ql_i  (qly[g]),
      .d_i   (dmn_q[g]),
      .rem_o (remy[g+1]),
      .ql_o  (qly[g+1])
    );
  end

  // Output stage: signed floor quotient plus scaled start, truncated toward zero.
  logic                 fracx, fracy;
  logic signed [QB:0]   fx, fy, sx, sy, tx, ty;
  logic signed [PW-1:0] cx_d, cy_d;
  logic                 hit_q;
  logic signed [PW-1:0] cx_q, cy_q;
  logic signed [SW-1:0] rba_q, rbs_q, rae_q, ras_q;

  always_comb begin
    fracx = (remx[QB] != '0);
    fracy = (remy[QB] != '0);
    fx    = negx_p[QB] ? -$signed({1'b0, qlx[QB]}) - (QB+1)'(fracx)
                       : $signed({1'b0, qlx[QB]});
    fy    = negy_p[QB] ? -$signed({1'b0, qly[QB]}) - (QB+1)'(fracy)
                       : $signed({1'b0, qly[QB]});
    sx    = (QB+1)'(asx_p[QB]) <<< FB;
    sy    = (QB+1)'(asy_p[QB]) <<< FB;
    tx    = sx + fx;
    ty    = sy + fy;
    if (fracx && tx[QB]) begin
      tx = tx + (QB+1)'(1);
    end
    if (fracy && ty[QB]) begin
      ty = ty + (QB+1)'(1);
    end
    if (hit_p[QB] && !mnz_p[QB]) begin
      cx_d = tx[PW-1:0];
      cy_d = ty[PW-1:0];
    end else begin
      cx_d = '0;
      cy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q <= hit_p[QB];
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      rba_q <= rba_p[QB];
      rbs_q <= rbs_p[QB];
      rae_q <= rae_p[QB];
      ras_q <= ras_p[QB];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_W'({ras_q, rae_q, rbs_q, rba_q, cy_q, cx_q, hit_q});

  // A miss always reports the origin as crossing point.
  `ASSERT_DFLT(a_miss_zero, out_vld_q && !hit_q |-> (cx_q == '0) && (cy_q == '0), "miss with nonzero point")
  // A hit means segment B straddles the line of A.
  `ASSERT_DFLT(a_hit_on_a, out_vld_q && hit_q |-> ((~rba_q[SW-1] && (rba_q != '0)) != (~rbs_q[SW-1] && (rbs_q != '0))), "hit without straddle on A")
  // A hit means segment A straddles the line of B.
  `ASSERT_DFLT(a_hit_on_b, out_vld_q && hit_q |-> ((~rae_q[SW-1] && (rae_q != '0)) != (~ras_q[SW-1] && (ras_q != '0))), "hit without straddle on B")
  // An accepted transaction occupies the first stage in the next cycle.
  `ASSERT_DFLT(a_enter, s_fire |=> vld_q[0], "accepted transaction lost")

endmodule

[sv/segi_div_step.sv]
// ---------------------------------------------------------------------------
// Division step
// One registered restoring-division step: produces one quotient bit.
// ---------------------------------------------------------------------------
module segi_div_step #(
  parameter int SW = 34,
  parameter int QB = 25
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [SW-1:0] rem_i,
  input  logic [QB-1:0] ql_i,
  input  logic [SW-1:0] d_i,
  output logic [SW-1:0] rem_o,
  output logic [QB-1:0] ql_o
);

  logic [SW:0]   sh;
  logic [SW+1:0] trial;
  logic          ge;
  logic [SW-1:0] rem_d;
  logic [QB-1:0] ql_d;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    sh    = {rem_i, ql_i[QB-1]};
    trial = {1'b0, sh} - {2'b00, d_i};
    ge    = ~trial[SW+1];
    rem_d = ge ? trial[SW-1:0] : sh[SW-1:0];
    ql_d  = {ql_i[QB-2:0], ge};
  end

  // Step register, advanced with the pipeline.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= rem_d;
      ql_o  <= ql_d;
    end
  end

endmodule
